>>> sv/assert_macros.svh
// Assertion macros used by the port-level checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is held
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

// Clocked property, checked during reset as well
`define ASSERT_ALWAYS_CLK(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("assertion failed");

`endif

>>> sv/rlse_pkg.sv
// Types and constants of the RGB LED SPI bit encoder
package rlse_pkg;

    localparam int COLOR_W        = 8;
    localparam int BYTE_W         = 8;
    localparam int PLEN_W         = 6;
    localparam int CFG_DW         = 8;
    localparam int CFG_AW         = 2;
    localparam int BITS_PER_PIXEL = 24;
    localparam int BIT_CNT_W      = $clog2(BITS_PER_PIXEL);
    localparam int MAX_PREAMBLE_DEF = 40;

    localparam logic [BYTE_W-1:0] ZERO_CODE_RST = ~8'b1110_0000;
    localparam logic [BYTE_W-1:0] ONE_CODE_RST  = ~8'b1111_1000;
    localparam logic [BYTE_W-1:0] IDLE_CODE_RST = ~8'b0000_0000;
    localparam logic [PLEN_W-1:0] PLEN_RST      = PLEN_W'(40);

    typedef enum logic [CFG_AW-1:0] {
        CFG_ZERO_CODE    = 2'd0,
        CFG_ONE_CODE     = 2'd1,
        CFG_IDLE_CODE    = 2'd2,
        CFG_PREAMBLE_LEN = 2'd3
    } t_cfg_idx;

    typedef struct packed {
        logic [COLOR_W-1:0] red;
        logic [COLOR_W-1:0] green;
        logic [COLOR_W-1:0] blue;
        logic               first_pixel;
    } t_pixel;

    typedef struct packed {
        logic [BYTE_W-1:0] spi_byte;
        logic              in_preamble;
        logic              last_of_run;
    } t_beat;

    typedef struct packed {
        logic [BYTE_W-1:0] zero_code;
        logic [BYTE_W-1:0] one_code;
        logic [BYTE_W-1:0] idle_code;
        logic [PLEN_W-1:0] preamble_len;
    } t_cfg;

endpackage

>>> sv/rlse_cfg_regs.sv
// Configuration register file: code bytes and preamble length
module rlse_cfg_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [rlse_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [rlse_pkg::CFG_DW-1:0] i_cfg_data,
    output rlse_pkg::t_cfg             o_cfg
);
    import rlse_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.zero_code    <= ZERO_CODE_RST;
            r_cfg.one_code     <= ONE_CODE_RST;
            r_cfg.idle_code    <= IDLE_CODE_RST;
            r_cfg.preamble_len <= PLEN_RST;
        end else if (i_cfg_we) begin
            unique case (t_cfg_idx'(i_cfg_idx))
                CFG_ZERO_CODE:    r_cfg.zero_code    <= i_cfg_data[BYTE_W-1:0];
                CFG_ONE_CODE:     r_cfg.one_code     <= i_cfg_data[BYTE_W-1:0];
                CFG_IDLE_CODE:    r_cfg.idle_code    <= i_cfg_data[BYTE_W-1:0];
                CFG_PREAMBLE_LEN: r_cfg.preamble_len <= i_cfg_data[PLEN_W-1:0];
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

>>> sv/rlse_serializer.sv
// Pixel holding register and byte sequencer: preamble count (first pixel only), then 24 color bits
module rlse_serializer #(
    parameter int MAX_PREAMBLE = rlse_pkg::MAX_PREAMBLE_DEF
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  rlse_pkg::t_cfg  i_cfg,
    input  logic            i_load,
    input  rlse_pkg::t_pixel i_pixel,
    input  logic            i_advance,
    output logic            o_ready,
    output logic            o_valid,
    output rlse_pkg::t_beat o_beat
);
    import rlse_pkg::*;

    localparam int PW = $clog2(MAX_PREAMBLE + 1);

    logic                      r_busy;
    logic [PW-1:0]             r_pre_cnt;
    logic [BIT_CNT_W-1:0]      r_bit_cnt;
    logic [BITS_PER_PIXEL-1:0] r_word;

    logic [PW-1:0] n_pre_len;
    logic          pre_phase;
    logic          last_bit;

    always_comb begin
        if (int'(i_cfg.preamble_len) > MAX_PREAMBLE) begin
            n_pre_len = PW'(MAX_PREAMBLE);
        end else begin
            n_pre_len = PW'(i_cfg.preamble_len);
        end
    end

    assign pre_phase = (r_pre_cnt != '0);
    assign last_bit  = !pre_phase && (r_bit_cnt == '0);
    assign o_ready   = !r_busy || (i_advance && last_bit);
    assign o_valid   = r_busy;

    always_comb begin
        o_beat.in_preamble = pre_phase;
        o_beat.last_of_run = last_bit;
        if (pre_phase) begin
            o_beat.spi_byte = i_cfg.idle_code;
        end else if (r_word[BITS_PER_PIXEL-1]) begin
            o_beat.spi_byte = i_cfg.one_code;
        end else begin
            o_beat.spi_byte = i_cfg.zero_code;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_pre_cnt <= '0;
            r_bit_cnt <= '0;
        end else if (i_load) begin
            r_busy    <= 1'b1;
            r_pre_cnt <= i_pixel.first_pixel ? n_pre_len : '0;
            r_bit_cnt <= BIT_CNT_W'(BITS_PER_PIXEL - 1);
        end else if (r_busy && i_advance) begin
            if (pre_phase) begin
                r_pre_cnt <= r_pre_cnt - 1'b1;
            end else if (last_bit) begin
                r_busy <= 1'b0;
            end else begin
                r_bit_cnt <= r_bit_cnt - 1'b1;
            end
        end
    end

    // color word, green first, shifted out MSB first
    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_word <= {i_pixel.green, i_pixel.red, i_pixel.blue};
        end else if (r_busy && i_advance && !pre_phase) begin
            r_word <= {r_word[BITS_PER_PIXEL-2:0], 1'b0};
        end
    end

endmodule

>>> sv/rgb_led_spi_bit_encoder_core.sv
// Top level of the RGB LED SPI bit encoder: config, sequencer, output register
// A pixel's bytes pass from the sequencer through the output register to o_beat.
// Throughput: one byte per cycle while i_stall is low; a pixel is 24 bytes plus the
// preamble length (capped at MAX_PREAMBLE) if first_pixel; the sequencer counts both.
// The next pixel is accepted in the cycle its predecessor's last byte moves out.
// Reset (synchronous, active low) empties the pipeline and restores the code registers.
module rgb_led_spi_bit_encoder_core #(
    parameter int MAX_PREAMBLE = rlse_pkg::MAX_PREAMBLE_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [rlse_pkg::CFG_AW-1:0] i_cfg_idx,
    input  logic [rlse_pkg::CFG_DW-1:0] i_cfg_data,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  rlse_pkg::t_pixel            i_pixel,
    output logic                        o_valid,
    input  logic                        i_stall,
    output rlse_pkg::t_beat             o_beat
);
    import rlse_pkg::*;

    t_cfg  cfg;
    t_beat ser_beat;
    logic  ser_valid;
    logic  ser_ready;
    logic  advance;
    logic  load;

    logic  r_out_valid;
    t_beat r_out;

    assign advance = !r_out_valid || !i_stall;
    assign load    = i_valid && ser_ready;
    assign o_stall = !ser_ready;

    rlse_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    rlse_serializer #(
        .MAX_PREAMBLE (MAX_PREAMBLE)
    ) u_ser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (cfg),
        .i_load    (load),
        .i_pixel   (i_pixel),
        .i_advance (advance),
        .o_ready   (ser_ready),
        .o_valid   (ser_valid),
        .o_beat    (ser_beat)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= ser_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && ser_valid) begin
            r_out <= ser_beat;
        end
    end

    assign o_valid = r_out_valid;
    assign o_beat  = r_out;

endmodule

>>> sv/rlse_checker.sv
// Port-level checker for the RGB LED SPI bit encoder, bound to the top level
`include "assert_macros.svh"

module rlse_checker (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_stall,
    input logic             o_valid,
    input logic             i_stall,
    input rlse_pkg::t_beat  o_beat
);
    import rlse_pkg::*;

    `ASSERT_ALWAYS_CLK(a_rst_clears_out, i_clk, !i_rst_n |=> !o_valid)

    `ASSERT_CLK(a_out_hold, i_clk, i_rst_n, o_valid && i_stall |=> o_valid && $stable(o_beat))

    `ASSERT_CLK(a_pre_not_last, i_clk, i_rst_n, o_valid && o_beat.in_preamble |-> !o_beat.last_of_run)

    `ASSERT_CLK(a_run_continues, i_clk, i_rst_n, o_valid && !i_stall && !o_beat.last_of_run |=> o_valid)

    `ASSERT_CLK(a_busy_stalls_in, i_clk, i_rst_n, o_valid && i_stall && !o_beat.last_of_run |-> o_stall)

endmodule

bind rgb_led_spi_bit_encoder_core rlse_checker u_rlse_checker (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .o_stall (o_stall),
    .o_valid (o_valid),
    .i_stall (i_stall),
    .o_beat  (o_beat)
);
